// File: design/wfc_pkg.sv
// shared types and constants for the word frequency counter
// used by wfc_cell and word_frequency_counter; no dependencies
`default_nettype none
package wfc_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int WORD_CHARS    = 32;
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
    localparam int POS_W  = $clog2(WORD_CHARS);
    localparam int LEN_W  = 6;
    localparam int CNT_W  = 16;

    localparam logic [7:0] CH_APOS  = 8'd39;
    localparam logic [7:0] CASE_OFS = 8'd32;
    localparam logic [7:0] UP_LO    = 8'd64;
    localparam logic [7:0] UP_HI    = 8'd91;
    localparam logic [7:0] LO_LO    = 8'd96;
    localparam logic [7:0] LO_HI    = 8'd123;
    localparam logic [7:0] DIG_LO   = 8'd47;
    localparam logic [7:0] DIG_HI   = 8'd58;

    typedef enum logic [1:0] {
        CMD_TEXT  = 2'd0,
        CMD_END   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_MANY = 2'd1,
        ST_TOO_LONG = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH
    } state_t;

    typedef logic [WORD_CHARS-1:0][7:0] word_t;

    typedef struct packed {
        logic hit;
        logic is_new;
    } cell_stat_t;

    typedef struct packed {
        logic [7:0]       chr;
        logic [CNT_W-1:0] count;
    } cell_rd_t;

endpackage
`default_nettype wire

// File: design/wfc_cell.sv
// one table entry of the counter chain: stored word, length and count
// depends on wfc_pkg
`default_nettype none
module wfc_cell (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire [wfc_pkg::IDX_W-1:0]  cell_idx,
    input  wire [wfc_pkg::USED_W-1:0] used,
    input  wire                       token_in,
    input  wfc_pkg::word_t            word,
    input  wire [wfc_pkg::LEN_W-1:0]  word_len,
    input  wire [wfc_pkg::POS_W-1:0]  rd_pos,
    output logic                      token_out,
    output wfc_pkg::cell_stat_t       stat,
    output wfc_pkg::cell_rd_t         rd
);
    import wfc_pkg::*;

    logic             tok_reg;
    word_t            chars_reg;
    logic [LEN_W-1:0] len_reg;
    logic [CNT_W-1:0] count_reg;
    logic             in_use;
    logic             match;
    logic [WORD_CHARS-1:0] eq;

    assign in_use = {1'b0, cell_idx} < used;

    always_comb
    begin
        for (int k = 0; k < WORD_CHARS; k++)
        begin
            eq[k] = (LEN_W'(k) >= word_len) || (chars_reg[k] == word[k]);
        end
        match = (len_reg == word_len) && (&eq);
    end

    assign stat.hit    = tok_reg && in_use && match;
    assign stat.is_new = tok_reg && !in_use;
    assign token_out   = tok_reg && in_use && !match;

    assign rd.chr   = ({1'b0, rd_pos} < len_reg) ? chars_reg[rd_pos] : 8'd0;
    assign rd.count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= token_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.is_new)
        begin
            chars_reg <= word;
            len_reg   <= word_len;
            count_reg <= CNT_W'(1);
        end
        else if (stat.hit && (count_reg != {CNT_W{1'b1}}))
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

endmodule
`default_nettype wire

// File: design/word_frequency_counter.sv
// word frequency counter: tokenizer, controller and the chain of table cells
// depends on wfc_pkg and wfc_cell
//
// requests arrive on in_valid/in_ready with cmd, text_byte, entry_index and
// char_position; each request gives exactly one result on out_valid/out_ready
// carrying status, unique_words, read_char and read_count.
// text bytes, reads, clears and a word end with no pending word are handled
// in the idle state and the result is shown in the next cycle.
// a word end with a pending word sends a search token down the cell chain, one
// cell per cycle, until a cell holding the word hits, the first unused cell
// takes the new word or the token leaves a full table (status too many).
// one request is in work at a time; the next request is taken as soon as the
// controller is idle and the output register is empty or being emptied.
// if the receiver stalls, the result stays in the output register and new
// requests wait.
// reset empties the table, clears the word and the error; table storage is
// not cleared, entries at or above unique_words are never read.
`default_nettype none
module word_frequency_counter (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire [1:0]  cmd,
    input  wire [7:0]  text_byte,
    input  wire [3:0]  entry_index,
    input  wire [4:0]  char_position,
    output logic       out_valid,
    input  wire        out_ready,
    output logic [1:0] status,
    output logic [4:0] unique_words,
    output logic [7:0] read_char,
    output logic [15:0] read_count
);
    import wfc_pkg::*;

    state_t            state_reg, state_next;
    status_t           err_reg, err_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              quote_reg, quote_next;
    word_t             word_reg, word_next;
    logic              ov_reg, ov_next;
    logic [1:0]        st_out_reg, st_out_next;
    logic [4:0]        uw_out_reg, uw_out_next;
    logic [7:0]        rc_out_reg, rc_out_next;
    logic [15:0]       cnt_out_reg, cnt_out_next;

    logic [TABLE_ENTRIES:0]   tok;
    cell_stat_t               stat_arr [TABLE_ENTRIES];
    cell_rd_t                 rd_arr [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] hit_vec, new_vec;

    logic       accept, start, load;
    logic       is_upper, is_alnum;
    logic [7:0] lc;
    logic [LEN_W-1:0] pos2;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++)
        begin : g_cell
            wfc_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cell_idx  (IDX_W'(g)),
                .used      (used_reg),
                .token_in  (tok[g]),
                .word      (word_reg),
                .word_len  (len_reg),
                .rd_pos    (char_position),
                .token_out (tok[g+1]),
                .stat      (stat_arr[g]),
                .rd        (rd_arr[g])
            );
            assign hit_vec[g] = stat_arr[g].hit;
            assign new_vec[g] = stat_arr[g].is_new;
        end
    endgenerate

    assign tok[0]   = start;
    assign in_ready = (state_reg == S_IDLE) && (!ov_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign is_upper = (text_byte > UP_LO) && (text_byte < UP_HI);
    assign is_alnum = is_upper || ((text_byte > LO_LO) && (text_byte < LO_HI))
                    || ((text_byte > DIG_LO) && (text_byte < DIG_HI));
    assign lc = is_upper ? text_byte + CASE_OFS : text_byte;

    always_comb
    begin
        state_next   = state_reg;
        err_next     = err_reg;
        used_next    = used_reg;
        len_next     = len_reg;
        quote_next   = quote_reg;
        word_next    = word_reg;
        start        = 1'b0;
        load         = 1'b0;
        rc_out_next  = 8'd0;
        cnt_out_next = 16'd0;
        pos2         = len_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load = 1'b1;
                    case (cmd_t'(cmd))
                        CMD_TEXT, CMD_END:
                        begin
                            if (err_reg == ST_OK)
                            begin
                                if (cmd_t'(cmd) == CMD_TEXT && text_byte == CH_APOS)
                                begin
                                    if (len_reg != '0)
                                    begin
                                        quote_next = 1'b1;
                                    end
                                end
                                else if (cmd_t'(cmd) == CMD_TEXT && is_alnum)
                                begin
                                    quote_next = 1'b0;
                                    if (quote_reg && len_reg >= LEN_W'(WORD_CHARS))
                                    begin
                                        err_next = ST_TOO_LONG;
                                        len_next = '0;
                                    end
                                    else
                                    begin
                                        if (quote_reg)
                                        begin
                                            word_next[len_reg[POS_W-1:0]] = CH_APOS;
                                            pos2 = len_reg + LEN_W'(1);
                                        end
                                        if (pos2 >= LEN_W'(WORD_CHARS))
                                        begin
                                            err_next = ST_TOO_LONG;
                                            len_next = '0;
                                        end
                                        else
                                        begin
                                            word_next[pos2[POS_W-1:0]] = lc;
                                            len_next = pos2 + LEN_W'(1);
                                        end
                                    end
                                end
                                else if (len_reg == '0)
                                begin
                                    quote_next = 1'b0;
                                end
                                else
                                begin
                                    // word end: walk the chain, result comes later
                                    start      = 1'b1;
                                    load       = 1'b0;
                                    state_next = S_SEARCH;
                                end
                            end
                        end
                        CMD_READ:
                        begin
                            if ({1'b0, entry_index} < used_reg)
                            begin
                                rc_out_next  = rd_arr[entry_index].chr;
                                cnt_out_next = rd_arr[entry_index].count;
                            end
                        end
                        default:
                        begin
                            used_next  = '0;
                            len_next   = '0;
                            quote_next = 1'b0;
                            err_next   = ST_OK;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if ((|hit_vec) || (|new_vec) || tok[TABLE_ENTRIES])
                begin
                    if (|new_vec)
                    begin
                        used_next = used_reg + USED_W'(1);
                    end
                    if (tok[TABLE_ENTRIES])
                    begin
                        err_next = ST_TOO_MANY;
                    end
                    len_next   = '0;
                    quote_next = 1'b0;
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        st_out_next = err_next;
        uw_out_next = 5'(used_next);
        ov_next     = (ov_reg && !out_ready) || load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            err_reg   <= ST_OK;
            used_reg  <= '0;
            len_reg   <= '0;
            quote_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
            used_reg  <= used_next;
            len_reg   <= len_next;
            quote_reg <= quote_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (load)
        begin
            st_out_reg  <= st_out_next;
            uw_out_reg  <= uw_out_next;
            rc_out_reg  <= rc_out_next;
            cnt_out_reg <= cnt_out_next;
        end
    end

    assign out_valid    = ov_reg;
    assign status       = st_out_reg;
    assign unique_words = uw_out_reg;
    assign read_char    = rc_out_reg;
    assign read_count   = cnt_out_reg;

    // only one cell can own the search token
    a_one_owner: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec | new_vec))
        else $error("more than one cell answered a search");

    // no token in the chain while idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ((hit_vec | new_vec) == '0) && !tok[TABLE_ENTRIES])
        else $error("search token seen while idle");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    // a clear always reports no error and an empty table
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_CLEAR) |=> (status == ST_OK) && (unique_words == 5'd0))
        else $error("clear did not reset status");

endmodule
`default_nettype wire
